// ===== hdl/jdcd_pkg.sv =====
// ----------------------------------------------------------------------------
// Julian day to calendar date: shared constants
// Scaled constants and reciprocals for the fixed-point form of the
// conversion, plus the month-start table used by the last pipeline stage.
// ----------------------------------------------------------------------------
package jdcd_pkg;

  localparam int unsigned NumStages = 10;

  // Gregorian correction applies from this day number upward.
  localparam logic [22:0] GregStart = 23'd2299161;

  // alpha = (4z - 7468865) / 146097, numerator below 2^25.
  localparam logic [24:0] AlphaOfs   = 25'd7468865;
  localparam logic [24:0] AlphaDiv   = 25'd146097;
  localparam logic [7:0]  AlphaRecip = 8'd229;     // floor(2^25 / 146097)

  // c = (20b - 2442) / 7305, numerator below 2^28.
  localparam logic [27:0] YearOfs    = 28'd2442;
  localparam logic [27:0] YearDiv    = 28'd7305;
  localparam logic [15:0] YearRecip  = 16'd36746;  // floor(2^28 / 7305)

  localparam logic [23:0] DayBias    = 24'd1524;
  localparam logic [25:0] QuadDays   = 26'd1461;

  // e = 10000 * rest / 306001, numerator below 2^23.
  localparam logic [22:0] MonScale   = 23'd10000;
  localparam logic [22:0] MonDiv     = 23'd306001;
  localparam logic [27:0] MonScaleRecip = 28'd270000;  // 10000 * floor(2^23 / 306001)

  localparam logic [15:0] YearBaseLate  = 16'd4716;
  localparam logic [15:0] YearBaseEarly = 16'd4715;

  // floor(306001 * e / 10000): day offset of the start of month index e.
  function automatic logic [8:0] month_start(input logic [3:0] e);
    logic [8:0] r;
    case (e)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd30;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd91;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd183;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd244;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd336;
      4'd12:   r = 9'd367;
      4'd13:   r = 9'd397;
      4'd14:   r = 9'd428;
      4'd15:   r = 9'd459;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/julian_day_to_calendar_date.sv =====
// ----------------------------------------------------------------------------
// Julian day to calendar date
// Ten register stages, stage 0 to stage 9; a date is valid on the output
// after its day number has passed through every stage.
// One item per cycle while stall_i is low; any stage with a free slot fills it.
// Reset clears every stage valid bit; the data registers are not reset.
// ----------------------------------------------------------------------------
module julian_day_to_calendar_date (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               stall_o,
  input  logic [22:0]        day_number_i,
  output logic               valid_o,
  input  logic               stall_i,
  output logic signed [15:0] year_o,
  output logic [3:0]         month_o,
  output logic [4:0]         day_o
);

  localparam int unsigned NS = jdcd_pkg::NumStages;

  logic [NS-1:0] v_q;
  logic [NS-1:0] en;

  // A stage loads when it is empty or when the stage after it moves on.
  always_comb begin
    en[NS-1] = !v_q[NS-1] || !stall_i;
    for (int i = NS - 2; i >= 0; i--) begin
      en[i] = !v_q[i] || en[i+1];
    end
  end

  assign stall_o = !en[0];
  assign valid_o = v_q[NS-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= valid_i;
      end
      for (int i = 1; i < NS; i++) begin
        if (en[i]) begin
          v_q[i] <= v_q[i-1];
        end
      end
    end
  end

  // Stage 0: capture, calendar select, alpha numerator.
  logic [22:0] s0_z_q;
  logic        s0_greg_q;
  logic [24:0] s0_n1_q;
  logic [24:0] s0_n1_d;

  assign s0_n1_d = {day_number_i, 2'b00} - jdcd_pkg::AlphaOfs;

  // Stage 1: reciprocal product for alpha.
  logic [22:0] s1_z_q;
  logic        s1_greg_q;
  logic [24:0] s1_n1_q;
  logic [32:0] s1_p1_q;
  logic [32:0] s1_p1_d;

  assign s1_p1_d = 33'(s0_n1_q) * 33'(jdcd_pkg::AlphaRecip);

  // Stage 2: alpha with remainder correction.
  logic [22:0] s2_z_q;
  logic        s2_greg_q;
  logic [7:0]  s2_alpha_q;
  logic [7:0]  alpha_est;
  logic [24:0] alpha_rem;
  logic [7:0]  s2_alpha_d;

  assign alpha_est  = s1_p1_q[32:25];
  assign alpha_rem  = s1_n1_q - 25'(alpha_est) * jdcd_pkg::AlphaDiv;
  assign s2_alpha_d = (alpha_rem >= jdcd_pkg::AlphaDiv) ? alpha_est + 8'd1 : alpha_est;

  // Stage 3: corrected day count b and the year numerator 20b - 2442.
  logic [23:0] s3_b_q;
  logic [27:0] s3_n2_q;
  logic [23:0] a_val;
  logic [23:0] s3_b_d;
  logic [27:0] s3_n2_d;

  always_comb begin
    if (s2_greg_q) begin
      a_val = {1'b0, s2_z_q} + 24'd1 + 24'(s2_alpha_q) - 24'(s2_alpha_q[7:2]);
    end else begin
      a_val = {1'b0, s2_z_q};
    end
  end

  assign s3_b_d  = a_val + jdcd_pkg::DayBias;
  assign s3_n2_d = {s3_b_d, 4'b0000} + 28'({s3_b_d, 2'b00}) - jdcd_pkg::YearOfs;

  // Stage 4: reciprocal product for the year count c.
  logic [23:0] s4_b_q;
  logic [27:0] s4_n2_q;
  logic [43:0] s4_p2_q;
  logic [43:0] s4_p2_d;

  assign s4_p2_d = 44'(s3_n2_q) * 44'(jdcd_pkg::YearRecip);

  // Stage 5: c with remainder correction.
  logic [23:0] s5_b_q;
  logic [14:0] s5_c_q;
  logic [14:0] c_est;
  logic [27:0] c_rem;
  logic [14:0] s5_c_d;

  assign c_est  = s4_p2_q[42:28];
  assign c_rem  = s4_n2_q - 28'(c_est) * jdcd_pkg::YearDiv;
  assign s5_c_d = (c_rem >= jdcd_pkg::YearDiv) ? c_est + 15'd1 : c_est;

  // Stage 6: days left in the shifted year, 123 to 488.
  logic [14:0] s6_c_q;
  logic [8:0]  s6_rest_q;
  logic [25:0] d_full;
  logic [8:0]  s6_rest_d;

  assign d_full    = 26'(s5_c_q) * jdcd_pkg::QuadDays;
  assign s6_rest_d = s5_b_q[8:0] - d_full[10:2];

  // Stage 7: scaled numerator and reciprocal product for the month index.
  logic [14:0] s7_c_q;
  logic [8:0]  s7_rest_q;
  logic [22:0] s7_n4_q;
  logic [27:0] s7_p4_q;
  logic [22:0] s7_n4_d;
  logic [27:0] s7_p4_d;

  assign s7_n4_d = 23'(s6_rest_q) * jdcd_pkg::MonScale;
  assign s7_p4_d = 28'(s6_rest_q) * jdcd_pkg::MonScaleRecip;

  // Stage 8: month index e with remainder correction.
  logic [14:0] s8_c_q;
  logic [8:0]  s8_rest_q;
  logic [3:0]  s8_e_q;
  logic [3:0]  e_est;
  logic [22:0] e_rem;
  logic [3:0]  s8_e_d;

  assign e_est  = s7_p4_q[26:23];
  assign e_rem  = s7_n4_q - 23'(e_est) * jdcd_pkg::MonDiv;
  assign s8_e_d = (e_rem >= jdcd_pkg::MonDiv) ? e_est + 4'd1 : e_est;

  // Stage 9: day of month, month and year.
  logic signed [15:0] s9_year_q;
  logic [3:0]         s9_month_q;
  logic [4:0]         s9_day_q;
  logic [8:0]         dom_full;
  logic [3:0]         s9_month_d;
  logic [15:0]        s9_year_d;
  logic [4:0]         s9_day_d;

  assign dom_full   = s8_rest_q - jdcd_pkg::month_start(s8_e_q);
  assign s9_day_d   = dom_full[4:0];
  assign s9_month_d = (s8_e_q < 4'd14) ? s8_e_q - 4'd1 : s8_e_q - 4'd13;
  assign s9_year_d  = {1'b0, s8_c_q} -
                      ((s9_month_d > 4'd2) ? jdcd_pkg::YearBaseLate
                                           : jdcd_pkg::YearBaseEarly);

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      s0_z_q    <= day_number_i;
      s0_greg_q <= (day_number_i >= jdcd_pkg::GregStart);
      s0_n1_q   <= s0_n1_d;
    end
    if (en[1]) begin
      s1_z_q    <= s0_z_q;
      s1_greg_q <= s0_greg_q;
      s1_n1_q   <= s0_n1_q;
      s1_p1_q   <= s1_p1_d;
    end
    if (en[2]) begin
      s2_z_q     <= s1_z_q;
      s2_greg_q  <= s1_greg_q;
      s2_alpha_q <= s2_alpha_d;
    end
    if (en[3]) begin
      s3_b_q  <= s3_b_d;
      s3_n2_q <= s3_n2_d;
    end
    if (en[4]) begin
      s4_b_q  <= s3_b_q;
      s4_n2_q <= s3_n2_q;
      s4_p2_q <= s4_p2_d;
    end
    if (en[5]) begin
      s5_b_q <= s4_b_q;
      s5_c_q <= s5_c_d;
    end
    if (en[6]) begin
      s6_c_q    <= s5_c_q;
      s6_rest_q <= s6_rest_d;
    end
    if (en[7]) begin
      s7_c_q    <= s6_c_q;
      s7_rest_q <= s6_rest_q;
      s7_n4_q   <= s7_n4_d;
      s7_p4_q   <= s7_p4_d;
    end
    if (en[8]) begin
      s8_c_q    <= s7_c_q;
      s8_rest_q <= s7_rest_q;
      s8_e_q    <= s8_e_d;
    end
    if (en[9]) begin
      s9_year_q  <= $signed(s9_year_d);
      s9_month_q <= s9_month_d;
      s9_day_q   <= s9_day_d;
    end
  end

  assign year_o  = s9_year_q;
  assign month_o = s9_month_q;
  assign day_o   = s9_day_q;

endmodule

// ===== bench/jdcd_date_checker.sv =====
// ----------------------------------------------------------------------------
// Julian day to calendar date: result checker
// Watches both channels of the converter and keeps one predicted date per
// accepted day number. It compares each accepted date field by field with
// the oldest prediction, and reports the number of failures and the number
// of dates still due.
// ----------------------------------------------------------------------------
module jdcd_date_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [22:0]        day_number_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic signed [15:0] year_i,
  input  logic [3:0]         month_i,
  input  logic [4:0]         day_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  typedef struct packed {
    logic signed [15:0] year;
    logic [3:0]         month;
    logic [4:0]         day;
  } cal_date_t;

  localparam logic [63:0] SwitchDay    = 64'(jdcd_pkg::GregStart);
  localparam logic [63:0] CenturyOfs   = 64'd7468865;
  localparam logic [63:0] FourCentury  = 64'd146097;
  localparam logic [63:0] DayOffset    = 64'd1524;
  localparam logic [63:0] YearOfs20    = 64'd2442;
  localparam logic [63:0] YearLen20    = 64'd7305;
  localparam logic [63:0] FourYears    = 64'd1461;
  localparam logic [63:0] MonthScale   = 64'd10000;
  localparam logic [63:0] MonthLen     = 64'd306001;

  cal_date_t due_dates[$];

  // Meeus conversion with every decimal constant scaled to an exact integer.
  function automatic cal_date_t calendar_of(input logic [22:0] jdn);
    logic [63:0]        z, a, b, c, d, rest, e, mon, alpha;
    logic signed [63:0] yr;
    cal_date_t          r;
    z = 64'(jdn);
    a = z;
    if (z >= SwitchDay) begin
      alpha = (4 * z - CenturyOfs) / FourCentury;
      a = z + 1 + alpha - alpha / 4;
    end
    b    = a + DayOffset;
    c    = (20 * b - YearOfs20) / YearLen20;
    d    = (FourYears * c) / 4;
    rest = b - d;
    e    = (MonthScale * rest) / MonthLen;
    mon  = (e < 14) ? e - 1 : e - 13;
    yr   = $signed(c) - ((mon > 2) ? 64'sd4716 : 64'sd4715);
    r.year  = yr[15:0];
    r.month = mon[3:0];
    r.day   = 5'(rest - (MonthLen * e) / MonthScale);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    cal_date_t want;
    if (!rst_ni) begin
      due_dates.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        due_dates.push_back(calendar_of(day_number_i));
      end
      if (out_valid_i && !out_stall_i) begin
        if (due_dates.size() == 0) begin
          $error("date %0d-%0d-%0d arrived with no day number waiting",
                 year_i, month_i, day_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = due_dates.pop_front();
          if (want.year !== year_i || want.month !== month_i || want.day !== day_i) begin
            fail_count_o <= fail_count_o + 1;
          end
          if (want.year !== year_i) begin
            $error("year: expected %0d, got %0d", want.year, year_i);
          end
          if (want.month !== month_i) begin
            $error("month: expected %0d, got %0d", want.month, month_i);
          end
          if (want.day !== day_i) begin
            $error("day: expected %0d, got %0d", want.day, day_i);
          end
        end
      end
      pending_o <= due_dates.size();
    end
  end

endmodule

// ===== bench/julian_day_to_calendar_date_test.sv =====
// ----------------------------------------------------------------------------
// Julian day to calendar date: testbench
// Sends directed day numbers (range ends, the calendar switch, year and month
// boundaries) and then random ones and runs of consecutive days, under
// phases of sender gaps and receiver stalls. A checker predicts every date.
// ----------------------------------------------------------------------------
module julian_day_to_calendar_date_test;

  localparam int QuietLimit = 1000;

  logic               clk        = 1'b0;
  logic               rst_n      = 1'b0;
  logic               in_valid   = 1'b0;
  logic               in_stall;
  logic [22:0]        day_number = '0;
  logic               out_valid;
  logic               out_stall  = 1'b0;
  logic signed [15:0] year;
  logic [3:0]         month;
  logic [4:0]         day;
  int                 fail_count;
  int                 pending;
  int                 sender_idle_pct    = 0;
  int                 receiver_stall_pct = 0;
  int                 quiet_cycles       = 0;

  julian_day_to_calendar_date dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .valid_i     (in_valid),
    .stall_o     (in_stall),
    .day_number_i(day_number),
    .valid_o     (out_valid),
    .stall_i     (out_stall),
    .year_o      (year),
    .month_o     (month),
    .day_o       (day)
  );

  jdcd_date_checker date_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .day_number_i(day_number),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .year_i      (year),
    .month_i     (month),
    .day_i       (day),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always #10 clk = ~clk;

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < receiver_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == QuietLimit) begin
      $display("julian_day_to_calendar_date test failed");
      $finish;
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance
  // with valid still high, so back-to-back items keep it high.
  task automatic send_day(input logic [22:0] d);
    if ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
      while ($urandom_range(99) < sender_idle_pct) @(negedge clk);
    end
    in_valid   <= 1'b1;
    day_number <= d;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain_dates();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  function automatic logic [22:0] pick_day();
    logic [22:0] d;
    case ($urandom_range(5))
      0:       d = jdcd_pkg::GregStart - 23'd400 + 23'($urandom_range(799));
      1:       d = 23'h7FFFFF - 23'($urandom_range(800));
      2:       d = 23'($urandom_range(800));
      3:       d = 23'($urandom_range(2500000, 2400000));
      default: d = 23'($urandom);
    endcase
    return d;
  endfunction

  // Mostly single random days, with runs of consecutive days that walk
  // across month and year boundaries.
  task automatic run_phase(input int idle_pct, input int stall_pct, input int n);
    int          sent;
    int          run_len;
    logic [22:0] base;
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    sent = 0;
    while (sent < n) begin
      base    = pick_day();
      run_len = ($urandom_range(3) == 0) ? $urandom_range(40, 5) : 1;
      for (int k = 0; k < run_len && sent < n; k++) begin
        send_day(base + 23'(k));
        sent++;
      end
    end
    drain_dates();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    send_day(23'd0);
    send_day(23'h7FFFFF);
    send_day(23'd1);
    send_day(23'h7FFFFE);
    // Around the switch from the Julian to the Gregorian calendar.
    send_day(23'd2299159);
    send_day(23'd2299160);
    send_day(23'd2299161);
    send_day(23'd2299162);
    send_day(23'h400000);
    send_day(23'h3FFFFF);
    send_day(23'h555555);
    send_day(23'h2AAAAA);
    // Year end, leap day and start of March in a Gregorian leap year.
    send_day(23'd2451544);
    send_day(23'd2451545);
    send_day(23'd2451604);
    send_day(23'd2451605);
    // Century year that is not a leap year.
    send_day(23'd2415079);
    send_day(23'd2415080);
    // Around the start of year one.
    send_day(23'd1721423);
    send_day(23'd1721424);
    send_day(23'd1721057);
    drain_dates();

    run_phase(0, 0, 135);
    run_phase(68, 0, 135);
    run_phase(0, 68, 135);
    run_phase(12, 12, 135);

    receiver_stall_pct = 0;
    drain_dates();
    repeat (jdcd_pkg::NumStages + 4) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("julian_day_to_calendar_date test passed");
    end else begin
      $display("julian_day_to_calendar_date test failed");
    end
    $finish;
  end

endmodule
